// ===== rtl/omkl_pkg.sv =====
// Shared types and constants for the offset multiset k-th largest unit.
`timescale 1ns / 1ps
`default_nettype none

package omkl_pkg;

  // Fixed field widths.
  localparam int unsigned VAL_W  = 20;
  localparam int unsigned DATA_W = 32;

  // Item kinds.
  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_ADD    = 2'd1,
    KIND_SUB    = 2'd2,
    KIND_QUERY  = 2'd3
  } kind_e;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_FOUND     = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_REFUSED   = 3'd4
  } status_e;

  // The offset is held within plus or minus this limit, so stored values fit 32 bits.
  localparam logic signed [33:0] OFF_MAX = 34'sd2146435072;
  localparam logic signed [33:0] OFF_MIN = -34'sd2146435072;

  // Limits of a reported true value.
  localparam logic signed [33:0] KTH_MAX = 34'sd2147483647;
  localparam logic signed [33:0] KTH_MIN = -34'sd2147483648;

endpackage

`default_nettype wire

// ===== rtl/omkl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module omkl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/omkl_alu.sv =====
// Shared adder and signed compare unit used by the start, threshold, eviction, insert and query steps of the sequencer.
`timescale 1ns / 1ps
`default_nettype none

module omkl_alu (
  input  logic signed [32:0] a_i,
  input  logic signed [32:0] b_i,
  input  logic               sub_i,
  output logic signed [33:0] res_o,
  output logic               lt_o
);

  logic signed [33:0] a_ext;
  logic signed [33:0] b_ext;

  // Sign-extend by one bit so that neither sum nor difference overflows.
  assign a_ext = {a_i[32], a_i};
  assign b_ext = {b_i[32], b_i};
  assign res_o = sub_i ? (a_ext - b_ext) : (a_ext + b_ext);

  // On a subtract the sign of the difference tells whether a is below b.
  assign lt_o = res_o[33];

endmodule

`default_nettype wire

// ===== rtl/offset_multiset_kth_largest_unit.sv =====
// Top level: sorted ring table in RAM, global offset and the item sequencer.
// Flow: a refused or full insert and a rank miss go straight to the result; an add clamps the
// new offset; a found query reads its entry, adds the offset and clamps; an admitted insert
// moves each greater entry up one place; a subtract clamps the offset, then binary-searches,
// with at most ceil(log2(count + 1)) steps. One item is in work at a time; the insert shift
// loop and the eviction search, each step through the shared adder, set how long it takes.
// Reset (rst_ni low, asynchronous) clears count, offset, counters and min_level; RAM is kept.
`timescale 1ns / 1ps
`default_nettype none

module offset_multiset_kth_largest_unit #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [19:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          kind_i,
  input  logic [19:0]         value_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [2:0]          status_o,
  output logic signed [31:0]  kth_value_o,
  output logic [10:0]         live_count_o,
  output logic [31:0]         evicted_total_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = AW + 2;

  typedef enum logic [11:0] {
    S_IDLE    = 12'b0000_0000_0001,
    S_START   = 12'b0000_0000_0010,
    S_CLAMP   = 12'b0000_0000_0100,
    S_THR     = 12'b0000_0000_1000,
    S_EV_RD   = 12'b0000_0001_0000,
    S_EV_CMP  = 12'b0000_0010_0000,
    S_EV_END  = 12'b0000_0100_0000,
    S_INS_RD  = 12'b0000_1000_0000,
    S_INS_CMP = 12'b0001_0000_0000,
    S_Q_WAIT  = 12'b0010_0000_0000,
    S_Q_CLAMP = 12'b0100_0000_0000,
    S_DONE    = 12'b1000_0000_0000
  } state_e;

  state_e                     state_q;
  omkl_pkg::kind_e            kind_q;
  logic [19:0]                val_q;
  logic [19:0]                min_level_q;
  logic [CW-1:0]              count_q;
  logic [AW-1:0]              base_q;
  logic signed [31:0]         offset_q;
  logic [31:0]                evicted_q;
  logic [CW-1:0]              pos_q;
  logic [CW-1:0]              hi_q;
  logic signed [32:0]         key_q;
  logic signed [33:0]         acc_q;
  omkl_pkg::status_e          status_q;
  logic signed [31:0]         kth_q;

  logic                       out_valid_q;
  omkl_pkg::status_e          out_status_q;
  logic signed [31:0]         out_kth_q;
  logic [10:0]                out_live_q;
  logic [31:0]                out_evicted_q;
  logic                       out_load;

  logic signed [32:0]         alu_a;
  logic signed [32:0]         alu_b;
  logic                       alu_sub;
  logic signed [33:0]         alu_res;
  logic                       alu_lt;

  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [31:0]                ram_wdata;
  logic                       ram_re;
  logic [AW-1:0]              ram_raddr;
  logic [31:0]                ram_rdata;

  logic [CW-1:0]              rd_idx;
  logic [CW:0]                mid_sum;
  logic [CW-1:0]              mid;
  logic                       q_bad;
  logic [32:0]                ev_sum;
  logic [31:0]                ev_next;
  logic signed [31:0]         off_clamped;
  logic signed [31:0]         kth_clamped;
  logic signed [32:0]         val_ext;
  logic signed [32:0]         off_ext;
  logic signed [32:0]         min_ext;
  logic signed [32:0]         rd_ext;

  // Logical table index to RAM address: the table is a ring starting at base_q.
  function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] base,
                                              input logic [CW-1:0] idx);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(idx);
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign in_ready_o = (state_q == S_IDLE);

  // A finished item loads the output register once it is free or being taken.
  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  // Operand extensions for the shared unit.
  assign val_ext = {13'd0, val_q};
  assign off_ext = {offset_q[31], offset_q};
  assign min_ext = {13'd0, min_level_q};
  assign rd_ext  = {ram_rdata[31], ram_rdata};

  // Binary search midpoint and query range check.
  assign mid_sum = {1'b0, pos_q} + {1'b0, hi_q};
  assign mid     = mid_sum[CW:1];
  assign q_bad   = (val_q == 20'd0) || (val_q > 20'(count_q));

  // Saturating eviction total and clamps.
  assign ev_sum  = {1'b0, evicted_q} + 33'(pos_q);
  assign ev_next = ev_sum[32] ? '1 : ev_sum[31:0];

  always_comb begin
    if (acc_q > omkl_pkg::OFF_MAX) begin
      off_clamped = omkl_pkg::OFF_MAX[31:0];
    end else if (acc_q < omkl_pkg::OFF_MIN) begin
      off_clamped = omkl_pkg::OFF_MIN[31:0];
    end else begin
      off_clamped = acc_q[31:0];
    end
  end

  always_comb begin
    if (acc_q > omkl_pkg::KTH_MAX) begin
      kth_clamped = omkl_pkg::KTH_MAX[31:0];
    end else if (acc_q < omkl_pkg::KTH_MIN) begin
      kth_clamped = omkl_pkg::KTH_MIN[31:0];
    end else begin
      kth_clamped = acc_q[31:0];
    end
  end

  // Operand selection for the shared adder.
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_q)
      S_START: begin
        case (kind_q)
          omkl_pkg::KIND_INSERT: begin
            alu_a   = val_ext;
            alu_b   = off_ext;
            alu_sub = 1'b1;
          end
          omkl_pkg::KIND_ADD: begin
            alu_a = off_ext;
            alu_b = val_ext;
          end
          omkl_pkg::KIND_SUB: begin
            alu_a   = off_ext;
            alu_b   = val_ext;
            alu_sub = 1'b1;
          end
          default: begin
            alu_a = '0;
          end
        endcase
      end
      S_THR: begin
        alu_a   = min_ext;
        alu_b   = off_ext;
        alu_sub = 1'b1;
      end
      S_EV_CMP: begin
        alu_a   = rd_ext;
        alu_b   = key_q;
        alu_sub = 1'b1;
      end
      S_INS_CMP: begin
        alu_a   = key_q;
        alu_b   = rd_ext;
        alu_sub = 1'b1;
      end
      S_Q_WAIT: begin
        alu_a = rd_ext;
        alu_b = off_ext;
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
  end

  omkl_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sub_i (alu_sub),
    .res_o (alu_res),
    .lt_o  (alu_lt)
  );

  // Table read index per state.
  always_comb begin
    case (state_q)
      S_START:  rd_idx = count_q - val_q[CW-1:0];
      S_EV_RD:  rd_idx = mid;
      S_INS_RD: rd_idx = pos_q - CW'(1);
      default:  rd_idx = '0;
    endcase
  end

  assign ram_re    = (state_q == S_START) || (state_q == S_EV_RD) || (state_q == S_INS_RD);
  assign ram_raddr = ring_addr(base_q, rd_idx);

  // Writes land at the insert position; entries greater than the key move up by one.
  assign ram_waddr = ring_addr(base_q, pos_q);
  assign ram_we    = ((state_q == S_INS_RD) && (pos_q == '0)) || (state_q == S_INS_CMP);
  assign ram_wdata = ((state_q == S_INS_CMP) && alu_lt) ? ram_rdata : key_q[31:0];

  omkl_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Sequencer and state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      kind_q        <= omkl_pkg::KIND_INSERT;
      val_q         <= '0;
      min_level_q   <= '0;
      count_q       <= '0;
      base_q        <= '0;
      offset_q      <= '0;
      evicted_q     <= '0;
      pos_q         <= '0;
      hi_q          <= '0;
      key_q         <= '0;
      acc_q         <= '0;
      status_q      <= omkl_pkg::ST_DONE;
      kth_q         <= '0;
      out_valid_q   <= 1'b0;
      out_status_q  <= omkl_pkg::ST_DONE;
      out_kth_q     <= '0;
      out_live_q    <= '0;
      out_evicted_q <= '0;
    end else begin
      if (cfg_we_i) begin
        min_level_q <= cfg_wdata_i;
      end

      // A finished item fills the output register; a taken result frees it.
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            kind_q   <= omkl_pkg::kind_e'(kind_i);
            val_q    <= value_i;
            status_q <= omkl_pkg::ST_DONE;
            kth_q    <= '0;
            state_q  <= S_START;
          end
        end
        S_START: begin
          case (kind_q)
            omkl_pkg::KIND_INSERT: begin
              if (val_q < min_level_q) begin
                status_q <= omkl_pkg::ST_REFUSED;
                state_q  <= S_DONE;
              end else if (count_q == CW'(DEPTH)) begin
                status_q <= omkl_pkg::ST_FULL;
                state_q  <= S_DONE;
              end else begin
                key_q   <= alu_res[32:0];
                pos_q   <= count_q;
                state_q <= S_INS_RD;
              end
            end
            omkl_pkg::KIND_ADD, omkl_pkg::KIND_SUB: begin
              acc_q   <= alu_res;
              state_q <= S_CLAMP;
            end
            default: begin
              if (q_bad) begin
                status_q <= omkl_pkg::ST_NOT_FOUND;
                state_q  <= S_DONE;
              end else begin
                state_q <= S_Q_WAIT;
              end
            end
          endcase
        end
        S_CLAMP: begin
          offset_q <= off_clamped;
          state_q  <= (kind_q == omkl_pkg::KIND_SUB) ? S_THR : S_DONE;
        end
        S_THR: begin
          // Entries whose stored value is below min_level - offset are evicted.
          key_q   <= alu_res[32:0];
          pos_q   <= '0;
          hi_q    <= count_q;
          state_q <= S_EV_RD;
        end
        S_EV_RD: begin
          state_q <= (pos_q == hi_q) ? S_EV_END : S_EV_CMP;
        end
        S_EV_CMP: begin
          if (alu_lt) begin
            pos_q <= mid + CW'(1);
          end else begin
            hi_q <= mid;
          end
          state_q <= S_EV_RD;
        end
        S_EV_END: begin
          // Drop the low entries by moving the ring start past them.
          base_q    <= ram_waddr;
          count_q   <= count_q - pos_q;
          evicted_q <= ev_next;
          state_q   <= S_DONE;
        end
        S_INS_RD: begin
          if (pos_q == '0) begin
            count_q <= count_q + CW'(1);
            state_q <= S_DONE;
          end else begin
            state_q <= S_INS_CMP;
          end
        end
        S_INS_CMP: begin
          if (alu_lt) begin
            pos_q   <= pos_q - CW'(1);
            state_q <= S_INS_RD;
          end else begin
            count_q <= count_q + CW'(1);
            state_q <= S_DONE;
          end
        end
        S_Q_WAIT: begin
          acc_q   <= alu_res;
          state_q <= S_Q_CLAMP;
        end
        S_Q_CLAMP: begin
          kth_q    <= kth_clamped;
          status_q <= omkl_pkg::ST_FOUND;
          state_q  <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            out_status_q  <= status_q;
            out_kth_q     <= kth_q;
            out_live_q    <= 11'(count_q);
            out_evicted_q <= evicted_q;
            state_q       <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign kth_value_o     = out_kth_q;
  assign live_count_o    = out_live_q;
  assign evicted_total_o = out_evicted_q;

endmodule

`default_nettype wire

// ===== rtl/omkl_checker.sv =====
// Port-level checker for the offset multiset k-th largest unit, with its bind.
`timescale 1ns / 1ps
`default_nettype none

module omkl_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic [2:0]         status_o,
  input wire logic signed [31:0] kth_value_o,
  input wire logic [10:0]        live_count_o,
  input wire logic [31:0]        evicted_total_o
);

  // After an input transfer the block is busy with that item.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("in_ready_o high right after an input transfer");

  // A stalled result holds all of its fields.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
      $stable(kth_value_o) && $stable(live_count_o) && $stable(evicted_total_o))
    else $error("stalled result changed");

  // Only defined status codes are reported.
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == omkl_pkg::ST_DONE || status_o == omkl_pkg::ST_FOUND ||
      status_o == omkl_pkg::ST_NOT_FOUND || status_o == omkl_pkg::ST_FULL ||
      status_o == omkl_pkg::ST_REFUSED))
    else $error("undefined status code");

  // A value is reported only with a found query.
  a_kth_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != omkl_pkg::ST_FOUND) |-> kth_value_o == 32'sd0)
    else $error("kth_value_o nonzero without a found query");

endmodule

bind offset_multiset_kth_largest_unit omkl_checker u_checker (.*);

`default_nettype wire
